### src/aabb_pkg.sv
// Shared types and constants for the box pair contact block.
package aabb_pkg;

   localparam int SHARE_BITS = 32;

   typedef enum logic [1:0] {
      DIR_POS_X = 2'd0,
      DIR_NEG_X = 2'd1,
      DIR_POS_Y = 2'd2,
      DIR_NEG_Y = 2'd3
   } dir_type;

   typedef enum logic [0:0] {
      REG_CORRECTION = 1'b0,
      REG_SLOP       = 1'b1
   } reg_index_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_a;
      logic capture_b;
      logic div_start;
      logic div_step;
      logic share_step;
      logic finish;
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_status_type;

   // saturate a wide signed value to 32 bits
   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -64'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

### src/aabb_ctrl.sv
// Sequencer for the contact block: load A, capture B, divide, apply, emit.
module aabb_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       req_type,
   input  aabb_pkg::dp_status_type    status,
   output logic                       busy,
   output aabb_pkg::ctl_cmd_type      cmd
);
   import aabb_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_SHARE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type) begin
                  cmd.capture_b = 1'b1;
                  state_in = ST_SETUP;
               end else begin
                  cmd.load_a = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_SHARE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_SHARE;
         end
         ST_SHARE: begin
            cmd.share_step = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   a_div_only_after_setup: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> state_ff == ST_SETUP) else $error("divide start outside setup");
   a_finish_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy) else $error("not idle after finish");
   a_capture_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture_b |=> busy) else $error("capture did not start a job");
`endif
endmodule

### src/aabb_dp.sv
// Datapath: held body A, contact geometry, mass share divider, impulse and shift.
module aabb_dp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  aabb_pkg::ctl_cmd_type   cmd,
   output aabb_pkg::dp_status_type status,
   input  logic                    csr_write,
   input  logic [0:0]              csr_index,
   input  logic [16:0]             csr_wdata,
   input  logic signed [31:0]      in_pos_x,
   input  logic signed [31:0]      in_pos_y,
   input  logic [30:0]             in_half_x,
   input  logic [30:0]             in_half_y,
   input  logic signed [31:0]      in_vel_x,
   input  logic signed [31:0]      in_vel_y,
   input  logic [30:0]             in_mass,
   input  logic [16:0]             in_bounce,
   output logic                    out_valid,
   output logic                    out_collided,
   output logic [1:0]              out_normal_dir,
   output logic signed [31:0]      out_penetration,
   output logic signed [31:0]      out_vel_a_x,
   output logic signed [31:0]      out_vel_a_y,
   output logic signed [31:0]      out_vel_b_x,
   output logic signed [31:0]      out_vel_b_y,
   output logic signed [31:0]      out_shift_a_x,
   output logic signed [31:0]      out_shift_a_y,
   output logic signed [31:0]      out_shift_b_x,
   output logic signed [31:0]      out_shift_b_y,
   output logic                    out_both_static
);
   import aabb_pkg::*;

   localparam logic [16:0] CORR_RESET = 17'((64'd1 << FRAC_BITS) / 5);
   localparam logic [16:0] SLOP_RESET = 17'((64'd1 << FRAC_BITS) / 100);
   localparam logic [33:0] ONE_FIX = 34'(64'd1 << FRAC_BITS);
   localparam int QW = SHARE_BITS + 1;   // quotient bits, share up to 2^32

   // configuration
   logic [16:0] corr_ff, slop_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         corr_ff <= CORR_RESET;
         slop_ff <= SLOP_RESET;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_CORRECTION: corr_ff <= csr_wdata;
            REG_SLOP:       slop_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // held body A
   logic signed [31:0] a_pos_ff [2];
   logic [30:0]        a_half_ff [2];
   logic signed [31:0] a_vel_ff [2];
   logic [30:0]        a_mass_ff;
   logic [16:0]        a_bounce_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_pos_ff[0] <= '0; a_pos_ff[1] <= '0;
         a_half_ff[0] <= '0; a_half_ff[1] <= '0;
         a_vel_ff[0] <= '0; a_vel_ff[1] <= '0;
         a_mass_ff <= '0; a_bounce_ff <= '0;
      end else if (cmd.load_a) begin
         a_pos_ff[0] <= in_pos_x; a_pos_ff[1] <= in_pos_y;
         a_half_ff[0] <= in_half_x; a_half_ff[1] <= in_half_y;
         a_vel_ff[0] <= in_vel_x; a_vel_ff[1] <= in_vel_y;
         a_mass_ff <= in_mass; a_bounce_ff <= in_bounce;
      end
   end

   // geometry from A and the incoming B, registered at capture
   logic signed [33:0] d_in [2], gap_in [2];
   always_comb begin
      d_in[0] = 34'(in_pos_x) - 34'(a_pos_ff[0]);
      d_in[1] = 34'(in_pos_y) - 34'(a_pos_ff[1]);
      for (int i = 0; i < 2; i++)
         gap_in[i] = (d_in[i] < 0 ? -d_in[i] : d_in[i])
                     - $signed({2'b0, 32'(a_half_ff[i])})
                     - $signed({2'b0, 32'(i == 0 ? in_half_x : in_half_y)});
   end

   logic               coll_ff, stat_ff, ax_ff, pos_ff, act_ff;
   logic signed [33:0] gap_ff;
   logic [33:0]        vmag_ff;       // |vn|
   logic [16:0]        e_ff;
   logic [30:0]        b_mass_ff;
   logic signed [31:0] b_vel_ff [2];

   logic               coll_c, stat_c, ax_c, pos_c, act_c;
   logic signed [33:0] vn_c;
   always_comb begin
      coll_c = gap_in[0] < 0 && gap_in[1] < 0;
      stat_c = a_mass_ff == '0 && in_mass == '0;
      ax_c   = !(gap_in[0] > gap_in[1]);
      pos_c  = (ax_c ? d_in[1] : d_in[0]) > 0;
      vn_c   = ax_c ? 34'(in_vel_y) - 34'(a_vel_ff[1]) : 34'(in_vel_x) - 34'(a_vel_ff[0]);
      if (!pos_c) vn_c = -vn_c;
      act_c  = coll_c && !stat_c && vn_c <= 0;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_b) begin
         coll_ff   <= coll_c;
         stat_ff   <= stat_c;
         ax_ff     <= ax_c;
         pos_ff    <= pos_c;
         act_ff    <= act_c;
         gap_ff    <= ax_c ? gap_in[1] : gap_in[0];
         vmag_ff   <= 34'(-vn_c);
         e_ff      <= a_bounce_ff < in_bounce ? a_bounce_ff : in_bounce;
         b_mass_ff <= in_mass;
         b_vel_ff[0] <= in_vel_x;
         b_vel_ff[1] <= in_vel_y;
      end
   end

   // radix-2 restoring divider: rA = mB*2^32/(mA+mB); rB = 2^32 - rA - (rem!=0)
   logic [31:0]  sum_ff;
   logic [32:0]  rem_ff;
   logic [QW-1:0] q_ff;
   logic [63:0]  num_ff;
   logic [5:0]   cnt_ff;
   logic [32:0]  rem_sh;
   assign rem_sh = {rem_ff[31:0], num_ff[63]};

   always_comb begin
      status.need_div = act_ff && a_mass_ff != '0 && b_mass_ff != '0;
      status.div_last = cnt_ff == 6'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         sum_ff <= 32'(a_mass_ff) + 32'(b_mass_ff);
         num_ff <= {1'b0, b_mass_ff, 32'd0};
         rem_ff <= '0;
         q_ff   <= '0;
         cnt_ff <= 6'd63;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[62:0], 1'b0};
         cnt_ff <= cnt_ff - 6'd1;
         if (rem_sh >= {1'b0, sum_ff}) begin
            rem_ff <= rem_sh - {1'b0, sum_ff};
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
      end
   end

   // shares and magnitudes
   logic [QW-1:0] ra_ff, rb_ff;
   logic [50:0]   jmag_ff, cmag_ff;
   logic          corr_on_ff;
   logic [33:0]   absgap;
   assign absgap = 34'(-gap_ff);

   always_ff @(posedge clock) begin
      if (cmd.share_step) begin
         if (a_mass_ff == '0) begin
            ra_ff <= '0; rb_ff <= QW'(64'd1 << SHARE_BITS);
         end else if (b_mass_ff == '0) begin
            ra_ff <= QW'(64'd1 << SHARE_BITS); rb_ff <= '0;
         end else begin
            ra_ff <= q_ff;
            rb_ff <= QW'(64'd1 << SHARE_BITS) - q_ff - QW'(rem_ff != '0);
         end
         jmag_ff <= 51'((68'(vmag_ff) * 68'(ONE_FIX + 34'(e_ff))) >> FRAC_BITS);
         cmag_ff <= 51'((51'(absgap) * 51'(corr_ff)) >> FRAC_BITS);
         corr_on_ff <= absgap > 34'(slop_ff);
      end
   end

   function automatic logic [50:0] share(input logic [50:0] x, input logic [QW-1:0] r);
      logic [83:0] p;
      p = 84'(x) * 84'(r);
      return 51'(p >> SHARE_BITS);
   endfunction

   // final sums, saturated
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else out_valid <= cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         logic signed [63:0] va [2], vb [2], sa [2], sb [2];
         logic signed [63:0] da, db, ca, cb;
         for (int i = 0; i < 2; i++) begin
            va[i] = 64'(a_vel_ff[i]); vb[i] = 64'(b_vel_ff[i]);
            sa[i] = '0; sb[i] = '0;
         end
         da = $signed(64'(share(jmag_ff, ra_ff)));
         db = $signed(64'(share(jmag_ff, rb_ff)));
         ca = $signed(64'(share(cmag_ff, ra_ff)));
         cb = $signed(64'(share(cmag_ff, rb_ff)));
         if (act_ff) begin
            va[ax_ff] = va[ax_ff] + (pos_ff ? -da : da);
            vb[ax_ff] = vb[ax_ff] + (pos_ff ? db : -db);
            if (corr_on_ff) begin
               sa[ax_ff] = pos_ff ? -ca : ca;
               sb[ax_ff] = pos_ff ? cb : -cb;
            end
         end
         out_collided    <= coll_ff;
         out_normal_dir  <= coll_ff ? {ax_ff, !pos_ff} : DIR_POS_X;
         out_penetration <= coll_ff ? sat32(64'(gap_ff)) : '0;
         out_vel_a_x <= sat32(va[0]); out_vel_a_y <= sat32(va[1]);
         out_vel_b_x <= sat32(vb[0]); out_vel_b_y <= sat32(vb[1]);
         out_shift_a_x <= sat32(sa[0]); out_shift_a_y <= sat32(sa[1]);
         out_shift_b_x <= sat32(sb[0]); out_shift_b_y <= sat32(sb[1]);
         out_both_static <= stat_ff;
      end
   end

`ifndef SYNTHESIS
   a_valid_one_cycle: assert property (@(posedge clock) disable iff (reset)
      out_valid |=> !out_valid) else $error("result strobe held");
   a_act_needs_contact: assert property (@(posedge clock) disable iff (reset)
      cmd.share_step && act_ff |-> coll_ff && !stat_ff) else $error("impulse without contact");
   a_div_counts_down: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && !status.div_last |=> cnt_ff == $past(cnt_ff) - 6'd1)
      else $error("divider count slipped");
`endif
endmodule

### src/aabb_pair_contact_impulse.sv
// Top level: contact test and impulse response for a pair of 2D boxes.
//  channel  | handshake           | payload
//  request  | start / busy        | req_type, req_pos_*, req_half_*, req_vel_*, req_mass, req_bounce
//  response | rsp_valid strobe    | rsp_collided ... rsp_both_static
//  csr      | csr_write           | csr_index, csr_wdata
// An A beat loads when start is seen. A B beat runs the setup, share and done states,
// plus the 64-step mass share divider when both masses are nonzero and an impulse applies.
// Reset is synchronous; it clears the held body and restores register defaults.
// The response strobe lasts one cycle; the receiver cannot stall it.
module aabb_pair_contact_impulse #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic [30:0]        req_half_x,
   input  logic [30:0]        req_half_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic [30:0]        req_mass,
   input  logic [16:0]        req_bounce,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [16:0]        csr_wdata,
   output logic               rsp_valid,
   output logic               rsp_collided,
   output logic [1:0]         rsp_normal_dir,
   output logic signed [31:0] rsp_penetration,
   output logic signed [31:0] rsp_new_vel_a_x,
   output logic signed [31:0] rsp_new_vel_a_y,
   output logic signed [31:0] rsp_new_vel_b_x,
   output logic signed [31:0] rsp_new_vel_b_y,
   output logic signed [31:0] rsp_shift_a_x,
   output logic signed [31:0] rsp_shift_a_y,
   output logic signed [31:0] rsp_shift_b_x,
   output logic signed [31:0] rsp_shift_b_y,
   output logic               rsp_both_static
);
   import aabb_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   aabb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_type(req_type),
      .status(status), .busy(busy), .cmd(cmd)
   );

   aabb_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_pos_x(req_pos_x), .in_pos_y(req_pos_y),
      .in_half_x(req_half_x), .in_half_y(req_half_y),
      .in_vel_x(req_vel_x), .in_vel_y(req_vel_y),
      .in_mass(req_mass), .in_bounce(req_bounce),
      .out_valid(rsp_valid), .out_collided(rsp_collided),
      .out_normal_dir(rsp_normal_dir), .out_penetration(rsp_penetration),
      .out_vel_a_x(rsp_new_vel_a_x), .out_vel_a_y(rsp_new_vel_a_y),
      .out_vel_b_x(rsp_new_vel_b_x), .out_vel_b_y(rsp_new_vel_b_y),
      .out_shift_a_x(rsp_shift_a_x), .out_shift_a_y(rsp_shift_a_y),
      .out_shift_b_x(rsp_shift_b_x), .out_shift_b_y(rsp_shift_b_y),
      .out_both_static(rsp_both_static)
   );
endmodule

### bench/tb_aabb_pair_contact_impulse.sv
// Self-checking bench for the box pair contact block: directed table, then random pairs.
module tb_aabb_pair_contact_impulse;
   import aabb_pkg::*;

   localparam int FRAC = 16;
   localparam int N_RANDOM = 1800;

   // one request beat
   typedef struct {
      bit               is_b;
      logic signed [31:0] px, py;
      logic [30:0]      hx, hy;
      logic signed [31:0] vx, vy;
      logic [30:0]      mass;
      logic [16:0]      bounce;
   } body_beat_type;

   // one response beat
   typedef struct {
      bit               hit;
      dir_type          dir;
      logic signed [31:0] pen;
      logic signed [31:0] vax, vay, vbx, vby;
      logic signed [31:0] sax, say, sbx, sby;
      bit               stat;
   } contact_type;

   // directed row: beat, plus optional typed-in expectation
   typedef struct {
      body_beat_type beat;
      bit            has_exp;
      contact_type   exp;
   } row_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy;
   logic req_type = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_vel_x = 0, req_vel_y = 0;
   logic [30:0] req_half_x = 0, req_half_y = 0, req_mass = 0;
   logic [16:0] req_bounce = 0;
   logic csr_write = 0;
   logic [0:0] csr_index = REG_CORRECTION;
   logic [16:0] csr_wdata = 0;
   logic rsp_valid, rsp_collided, rsp_both_static;
   logic [1:0] rsp_normal_dir;
   logic signed [31:0] rsp_penetration, rsp_new_vel_a_x, rsp_new_vel_a_y;
   logic signed [31:0] rsp_new_vel_b_x, rsp_new_vel_b_y;
   logic signed [31:0] rsp_shift_a_x, rsp_shift_a_y, rsp_shift_b_x, rsp_shift_b_y;

   aabb_pair_contact_impulse dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      #200000000;
      $display("*** FAILED ***");
      $finish;
   end

   // predictor state
   logic [16:0] corr_pct, slop;
   logic signed [63:0] a_pos [2];
   logic [63:0] a_half [2];
   logic signed [63:0] a_vel [2];
   logic [63:0] a_mass, a_bounce;

   contact_type pending_q [$];
   int errors = 0;
   int n_sent = 0;

   function automatic logic [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] take_share(input logic [63:0] x, input logic [63:0] r);
      if (r >= 64'h1_0000_0000) return x;
      return (x >> 32) * r + (((x & 64'hFFFF_FFFF) * r) >> 32);
   endfunction

   // predicted contact for a B beat; an A beat only updates the held body
   function automatic bit predict_contact(input body_beat_type b, output contact_type c);
      logic signed [63:0] pb [2], vb [2], va [2], sa [2], sb [2], d [2], g [2];
      logic signed [63:0] vn, ad, da, db, ca, cb;
      logic [63:0] hb [2], ra, rb, e, jmag, cmag, absgap, sum;
      int ax;
      bit pos;
      pb[0] = 64'(b.px); pb[1] = 64'(b.py); hb[0] = 64'(b.hx); hb[1] = 64'(b.hy);
      vb[0] = 64'(b.vx); vb[1] = 64'(b.vy);
      if (!b.is_b) begin
         a_pos = pb; a_half = hb; a_vel = vb;
         a_mass = 64'(b.mass); a_bounce = 64'(b.bounce);
         return 0;
      end
      for (int i = 0; i < 2; i++) begin
         d[i] = pb[i] - a_pos[i];
         ad = d[i] < 0 ? -d[i] : d[i];
         g[i] = ad - $signed(a_half[i] + hb[i]);
         va[i] = a_vel[i]; sa[i] = 0; sb[i] = 0;
      end
      c.hit = g[0] < 0 && g[1] < 0;
      c.stat = a_mass == 0 && b.mass == 0;
      c.dir = DIR_POS_X;
      c.pen = 0;
      if (c.hit) begin
         ax = g[0] > g[1] ? 0 : 1;
         pos = d[ax] > 0;
         c.dir = dir_type'(ax * 2 + (pos ? 0 : 1));
         c.pen = clamp32(g[ax]);
         absgap = -g[ax];
         if (!c.stat) begin
            vn = vb[ax] - va[ax];
            if (!pos) vn = -vn;
            if (vn <= 0) begin
               if (a_mass == 0) begin
                  ra = 0; rb = 64'h1_0000_0000;
               end else if (b.mass == 0) begin
                  ra = 64'h1_0000_0000; rb = 0;
               end else begin
                  sum = a_mass + 64'(b.mass);
                  ra = (64'(b.mass) << 32) / sum;
                  rb = (a_mass << 32) / sum;
               end
               e = a_bounce < 64'(b.bounce) ? a_bounce : 64'(b.bounce);
               jmag = (64'(-vn) * ((64'd1 << FRAC) + e)) >> FRAC;
               da = take_share(jmag, ra);
               db = take_share(jmag, rb);
               va[ax] += pos ? -da : da;
               vb[ax] += pos ? db : -db;
               if (absgap > 64'(slop)) begin
                  cmag = (absgap * 64'(corr_pct)) >> FRAC;
                  ca = take_share(cmag, ra);
                  cb = take_share(cmag, rb);
                  sa[ax] = pos ? -ca : ca;
                  sb[ax] = pos ? cb : -cb;
               end
            end
         end
      end
      c.vax = clamp32(va[0]); c.vay = clamp32(va[1]);
      c.vbx = clamp32(vb[0]); c.vby = clamp32(vb[1]);
      c.sax = clamp32(sa[0]); c.say = clamp32(sa[1]);
      c.sbx = clamp32(sb[0]); c.sby = clamp32(sb[1]);
      return 1;
   endfunction

   task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %0d got %0d", name, $signed(e), $signed(a));
         errors++;
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      contact_type e;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $error("unexpected response beat");
            errors++;
         end else begin
            e = pending_q.pop_front();
            check_field("collided", 32'(e.hit), 32'(rsp_collided));
            check_field("normal_dir", 32'(e.dir), 32'(rsp_normal_dir));
            check_field("penetration", e.pen, rsp_penetration);
            check_field("new_vel_a_x", e.vax, rsp_new_vel_a_x);
            check_field("new_vel_a_y", e.vay, rsp_new_vel_a_y);
            check_field("new_vel_b_x", e.vbx, rsp_new_vel_b_x);
            check_field("new_vel_b_y", e.vby, rsp_new_vel_b_y);
            check_field("shift_a_x", e.sax, rsp_shift_a_x);
            check_field("shift_a_y", e.say, rsp_shift_a_y);
            check_field("shift_b_x", e.sbx, rsp_shift_b_x);
            check_field("shift_b_y", e.sby, rsp_shift_b_y);
            check_field("both_static", 32'(e.stat), 32'(rsp_both_static));
         end
      end
   end

   bit no_gaps = 0;

   // drive one beat; waits for acceptance, then queues its prediction
   task automatic send_beat(input body_beat_type b, input bit has_exp,
                            input contact_type typed);
      contact_type c;
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      repeat (gap) @(negedge clock);
      req_type = b.is_b; req_pos_x = b.px; req_pos_y = b.py;
      req_half_x = b.hx; req_half_y = b.hy; req_vel_x = b.vx; req_vel_y = b.vy;
      req_mass = b.mass; req_bounce = b.bounce;
      start = 1;
      do @(posedge clock); while (busy);
      n_sent++;
      if (predict_contact(b, c)) begin
         if (has_exp) c = typed;
         pending_q.insert(pending_q.size(), c);
      end
      @(negedge clock);
      start = 0;
   endtask

   task automatic drain_and_wait();
      int guard = 0;
      while (pending_q.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [16:0] v);
      csr_index = idx; csr_wdata = v; csr_write = 1;
      @(negedge clock);
      csr_write = 0;
      if (idx == REG_CORRECTION) corr_pct = v; else slop = v;
   endtask

   function automatic body_beat_type mk(input bit is_b, input int px, input int py,
                                        input int hx, input int hy, input int vx,
                                        input int vy, input int m, input int bo);
      body_beat_type b;
      b.is_b = is_b; b.px = px; b.py = py; b.hx = 31'(hx); b.hy = 31'(hy);
      b.vx = vx; b.vy = vy; b.mass = 31'(m); b.bounce = 17'(bo);
      return b;
   endfunction

   function automatic logic [31:0] rnd_signed();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return $signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC);
      endcase
   endfunction

   function automatic logic [30:0] rnd_unsigned(input int typ_max);
      case ($urandom_range(0, 5))
         0: return 31'h7FFF_FFFF;
         1: return 0;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, typ_max));
      endcase
   endfunction

   function automatic body_beat_type rnd_body(input bit is_b);
      body_beat_type b;
      b.is_b = is_b;
      b.px = rnd_signed(); b.py = rnd_signed();
      b.hx = rnd_unsigned(8 << FRAC); b.hy = rnd_unsigned(8 << FRAC);
      b.vx = rnd_signed(); b.vy = rnd_signed();
      b.mass = $urandom_range(0, 3) == 0 ? 31'd0 : rnd_unsigned(100 << FRAC);
      b.bounce = $urandom_range(0, 4) == 0 ? 17'h1FFFF : 17'($urandom_range(0, 65536));
      return b;
   endfunction

   row_type rows [$];
   contact_type z;

   initial begin
      row_type r;
      int phase_end;
      corr_pct = 13107; slop = 655;
      a_pos = '{0, 0}; a_half = '{0, 0}; a_vel = '{0, 0}; a_mass = 0; a_bounce = 0;
      repeat (2) @(negedge clock);
      reset = 0;

      z = '{hit: 0, dir: DIR_POS_X, stat: 1, default: 0};
      // B before any A: held body is zero, zero-size boxes cannot overlap
      r.beat = mk(1, 0, 0, 0, 0, 0, 0, 0, 0); r.has_exp = 1; r.exp = z;
      rows.insert(rows.size(), r);
      r.has_exp = 0;
      // head-on along x, equal masses
      r.beat = mk(0, 0, 0, 2 << 16, 1 << 16, 1 << 16, 0, 1 << 16, 32768);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 3 << 16, 0, 2 << 16, 4 << 16, -(1 << 16), 0, 1 << 16, 65536);
      rows.insert(rows.size(), r);
      // -x normal, y normal both signs, diagonal offset, zero distance
      r.beat = mk(1, -(3 << 16), 0, 2 << 16, 4 << 16, 1 << 16, 0, 3 << 16, 0);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 0, 1 << 16, 4 << 16, 1 << 16, 0, -(1 << 16), 2 << 16, 0);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 0, -(1 << 16), 4 << 16, 1 << 16, 5, 7, 2 << 16, 0);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 1 << 16, 1 << 16, 2 << 16, 1 << 16, 0, 0, 1 << 16, 0);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 0, 0, 1 << 16, 1 << 16, 0, 0, 1 << 16, 0);
      rows.insert(rows.size(), r);
      // separating bodies
      r.beat = mk(1, 3 << 16, 0, 2 << 16, 4 << 16, 9 << 16, 0, 1 << 16, 0);
      rows.insert(rows.size(), r);
      // B static
      r.beat = mk(1, 3 << 16, 0, 2 << 16, 4 << 16, -(1 << 16), 0, 0, 65536);
      rows.insert(rows.size(), r);
      // A static, both static, overlap below slop, saturating velocities
      r.beat = mk(0, 0, 0, 2 << 16, 2 << 16, 0, 0, 0, 65536);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 3 << 16, 0, 2 << 16, 4 << 16, -(1 << 16), 0, 5 << 16, 65536);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 3 << 16, 0, 2 << 16, 4 << 16, -(1 << 16), 0, 0, 0);
      rows.insert(rows.size(), r);
      r.beat = mk(1, (4 << 16) - 100, 0, 2 << 16, 4 << 16, -1, 0, 1, 0);
      rows.insert(rows.size(), r);
      r.beat = mk(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  31'h7FFF_FFFF, 17'h1FFFF);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 17'h1FFFF);
      rows.insert(rows.size(), r);
      r.beat = mk(1, 1, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 0, 1, 17'h1FFFF);
      rows.insert(rows.size(), r);

      foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp);
      drain_and_wait();

      // random pairs across register settings, including the extremes
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(REG_CORRECTION, 0); write_reg(REG_SLOP, 0); end
            1: begin write_reg(REG_CORRECTION, 65536); write_reg(REG_SLOP, 65536); end
            2: begin write_reg(REG_CORRECTION, 17'h1FFFF); write_reg(REG_SLOP, 17'h1FFFF); end
            default: begin
               write_reg(REG_CORRECTION, 17'($urandom_range(0, 17'h1FFFF)));
               write_reg(REG_SLOP, 17'($urandom_range(0, 17'h1FFFF)));
            end
         endcase
         no_gaps = phase == 4;
         phase_end = n_sent + N_RANDOM / 6;
         while (n_sent < phase_end) begin
            body_beat_type a, b;
            int n;
            case ($urandom_range(0, 9))
               0: send_beat(rnd_body(1'($urandom_range(0, 1))), 0, z);
               1: send_beat(rnd_body(1), 0, z);
               default: begin
                  a = rnd_body(0);
                  send_beat(a, 0, z);
                  n = $urandom_range(1, 3);
                  for (int j = 0; j < n; j++) begin
                     b = rnd_body(1);
                     // mostly place B near A so boxes overlap
                     if ($urandom_range(0, 3) != 0) begin
                        b.px = a.px + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
                        b.py = a.py + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
                        b.hx = 31'($urandom_range(1, 4 << 16));
                        b.hy = 31'($urandom_range(1, 4 << 16));
                     end
                     send_beat(b, 0, z);
                  end
               end
            endcase
         end
         drain_and_wait();
      end

      if (errors == 0 && pending_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (pending_q.size() != 0) $error("%0d responses never arrived", pending_q.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
